[rtl/sli_pkg.sv]
package sli_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 6;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DATA_W   = 64;
	localparam int LVLS     = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_INSERT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_RANGE     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef enum logic [2:0] {
		C_HOLD  = 3'd0,
		C_LOAD  = 3'd1,
		C_LOWER = 3'd2,
		C_UPPER = 3'd3,
		C_ZERO  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     capture;
		logic     in_use;
	} cell_ctl_t;

endpackage

[rtl/sli_cell.sv]
module sli_cell
	import sli_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] item_value,
	input  logic [DATA_W-1:0] lower_data,
	input  logic [DATA_W-1:0] upper_data,
	output logic [DATA_W-1:0] data,
	output logic              hit
);

	logic [DATA_W-1:0] data_q;
	logic              hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			case (ctl.op)
				C_LOAD:  data_q <= item_value;
				C_LOWER: data_q <= lower_data;
				C_UPPER: data_q <= upper_data;
				C_ZERO:  data_q <= '0;
				default: data_q <= data_q;
			endcase
		end
	end

	// match flag, sampled when a request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.capture) begin
			hit_q <= ctl.in_use && (data_q == item_value);
		end
	end

	assign data = data_q;
	assign hit  = hit_q;

endmodule

[rtl/sli_scan.sv]
module sli_scan
	import sli_pkg::*;
(
	input  logic [CAPACITY-1:0] hit,
	output logic [CAPACITY-1:0] seen
);

	// inclusive prefix OR, log-depth
	logic [CAPACITY-1:0] lvl [0:LVLS];

	assign lvl[0] = hit;

	for (genvar l = 0; l < LVLS; l++) begin : g_lvl
		for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign seen = lvl[LVLS];

endmodule

[rtl/shift_list_insert_remove_core.sv]
// A taken request moves the core into its execute state; the result strobe (done) is registered from that state.
// No new request is taken during the execute cycle; busy is high for the one execute cycle.
// The execute cycle holds the priority scan over the registered match flags of all cells.
// Reset (arst_n low, asynchronous): list empty, all cells zero, no result pending.
// The receiver cannot stall: done lasts exactly one cycle.
module shift_list_insert_remove_core
	import sli_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] item_value,
	output logic              done,
	output logic [1:0]        status,
	output logic [6:0]        entry_count
);

	state_t              state_q, state_d;
	func_t               func_q;
	logic [POS_W-1:0]    pos_q;
	logic [DATA_W-1:0]   val_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                done_q;
	status_t             status_q, status_d;

	logic                take;
	logic                exec;
	logic                full;
	logic                pos_bad;
	logic                found;

	logic [CMP_W-1:0]    count_x;
	logic [CMP_W-1:0]    pos_x;

	cell_ctl_t           ctl [CAPACITY];
	logic [DATA_W-1:0]   cell_data [CAPACITY];
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] seen;

	assign take    = start && (state_q == ST_IDLE);
	assign exec    = (state_q == ST_EXEC);
	assign busy    = exec;
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign count_x = CMP_W'(count_q);
	assign pos_x   = CMP_W'(pos_q);
	assign pos_bad = (pos_x >= count_x);
	assign found   = seen[CAPACITY-1];

	// request registers; cells sample their match flags at the same edge
	always_ff @(posedge clk) begin
		if (take) begin
			func_q <= func_t'(func);
			pos_q  <= position;
			val_q  <= item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= STS_OK;
		end else begin
			state_q <= state_d;
			done_q  <= exec;
			if (exec) begin
				count_q  <= count_d;
				status_q <= status_d;
			end
		end
	end

	// next state, status and new count
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		status_d = STS_OK;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				case (func_q)
					FN_APPEND: begin
						if (full) begin
							status_d = STS_FULL;
						end else begin
							count_d = count_q + 1'b1;
						end
					end
					FN_INSERT: begin
						if (pos_bad) begin
							status_d = STS_RANGE;
						end else if (full) begin
							status_d = STS_FULL;
						end else begin
							count_d = count_q + 1'b1;
						end
					end
					FN_REMOVE: begin
						if (found) begin
							count_d = count_q - 1'b1;
						end else begin
							status_d = STS_NOT_FOUND;
						end
					end
					default: begin
						count_d = '0;
					end
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	sli_scan u_scan (
		.hit  (hit),
		.seen (seen)
	);

	// per-cell commands and the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
		logic [DATA_W-1:0] lower_d;
		logic [DATA_W-1:0] upper_d;

		always_comb begin
			ctl[i].capture = take;
			ctl[i].in_use  = (IDX < count_x);
			ctl[i].op      = C_HOLD;
			if (exec) begin
				case (func_q)
					FN_APPEND: begin
						if (!full && (IDX == count_x)) begin
							ctl[i].op = C_LOAD;
						end
					end
					FN_INSERT: begin
						if (!pos_bad && !full) begin
							if (IDX == pos_x) begin
								ctl[i].op = C_LOAD;
							end else if (IDX > pos_x) begin
								ctl[i].op = C_LOWER;
							end
						end
					end
					FN_REMOVE: begin
						// every cell at or above the first match pulls from above
						if (seen[i]) begin
							ctl[i].op = C_UPPER;
						end
					end
					default: ctl[i].op = C_ZERO;
				endcase
			end
		end

		if (i == 0) begin : g_first
			assign lower_d = '0;
		end else begin : g_mid_lo
			assign lower_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_d = '0;
		end else begin : g_mid_hi
			assign upper_d = cell_data[i+1];
		end

		sli_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[i]),
			.item_value (exec ? val_q : item_value),
			.lower_data (lower_d),
			.upper_data (upper_d),
			.data       (cell_data[i]),
			.hit        (hit[i])
		);
	end

	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = 7'(count_q);

	// execute lasts exactly one cycle
	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> !exec) else $error("execute cycle did not end");

	// every taken request yields a result strobe, registered after its execute cycle
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ##1 done) else $error("missing result strobe");

	// count stays within capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY)) else $error("count above capacity");

	// failed operations leave the count unchanged
	a_fail_keep: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q != STS_OK) |-> $stable(count_q))
		else $error("count changed on failed request");

	// a successful remove lowers the count by one
	a_rm_dec: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (func_q == FN_REMOVE) && found |=> (count_q == $past(count_q) - 1'b1))
		else $error("remove did not lower count");

endmodule
